/* rtl/core/particle_swarm_velocity_update_defines.svh */
// Assertion macros used by the checker file.
`ifndef PARTICLE_SWARM_VELOCITY_UPDATE_DEFINES_SVH
`define PARTICLE_SWARM_VELOCITY_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PSVU_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psvu check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define PSVU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psvu check failed");

`endif

/* rtl/core/psvu_pkg.sv */
package psvu_pkg;

   localparam int MaxDim     = 8;
   localparam int DimW       = 3;
   localparam int PidxW      = 6;
   localparam int ScoreW     = 41;
   localparam int SumW       = 53;
   localparam int ScaleShift = 28;

   localparam logic [ScoreW-1:0] SCORE_MAX = '1;

   // operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_FIRST = 2'd1;
   localparam logic [1:0] OP_OPT   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_INERTIA = 3'd0;
   localparam logic [2:0] CSR_PGAIN   = 3'd1;
   localparam logic [2:0] CSR_GGAIN   = 3'd2;
   localparam logic [2:0] CSR_VLIMIT  = 3'd3;
   localparam logic [2:0] CSR_VLENGTH = 3'd4;

   typedef struct packed {
      logic            load;
      logic            clear;
      logic            cmp;
      logic            copy;
      logic            rd;
      logic            mul;
      logic            sum;
      logic            rnd;
      logic [DimW-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic            in_last;
      logic            opt;
      logic            pupd;
      logic [DimW-1:0] len_m1;
   } sts_type;

endpackage

/* rtl/core/psvu_dp.sv */
module psvu_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_data,
   input  logic [psvu_pkg::PidxW-1:0] particle_index,
   input  logic signed [15:0]         position,
   input  logic signed [15:0]         velocity,
   input  logic signed [15:0]         target,
   input  logic [15:0]                rand_one,
   input  logic [15:0]                rand_two,
   input  logic                       set_opt,
   input  logic                       set_first,
   input  psvu_pkg::cmd_type          cmd,
   output psvu_pkg::sts_type          sts,
   output logic [15:0]                new_velocity,
   output logic [psvu_pkg::DimW-1:0]  element_index,
   output logic                       last
);

   localparam int PbDepth = (1 << psvu_pkg::PidxW) * psvu_pkg::MaxDim;
   localparam int ScDepth = 1 << psvu_pkg::PidxW;

   // configuration
   logic signed [15:0] w_ff, c1_ff, c2_ff;
   logic [14:0]        vlim_ff;
   logic [3:0]         vlen_ff;

   // load side
   logic signed [15:0]                pbuf_ff [psvu_pkg::MaxDim];
   logic signed [15:0]                vbuf_ff [psvu_pkg::MaxDim];
   logic [psvu_pkg::ScoreW-1:0]       acc_ff, score_ff, gscore_ff;
   logic [psvu_pkg::DimW-1:0]         cnt_ff;
   logic [psvu_pkg::PidxW-1:0]        p_ff;
   logic                              opt_ff, first_ff;
   logic [15:0]                       r1_ff, r2_ff;

   // best storage
   logic signed [15:0]                pb_mem [PbDepth];
   logic [psvu_pkg::ScoreW-1:0]       sc_mem [ScDepth];
   logic [ScDepth-1:0]                scv_ff;
   logic [psvu_pkg::ScoreW-1:0]       sc_rd_ff;
   logic                              scv_rd_ff;
   logic signed [15:0]                gpos_ff [psvu_pkg::MaxDim];

   // velocity path
   logic signed [32:0]                k1_ff, k2_ff;
   logic signed [15:0]                pb_rd_ff, gb_rd_ff, p_rd_ff, v_rd_ff;
   logic [psvu_pkg::DimW-1:0]         idx_ff;
   logic signed [31:0]                pv_ff;
   logic signed [49:0]                m1_ff, m2_ff;
   logic signed [psvu_pkg::SumW-1:0]  s_ff;
   logic [15:0]                       nv_ff;
   logic [psvu_pkg::DimW-1:0]         eidx_ff;
   logic                              last_ff;

   logic [psvu_pkg::DimW-1:0]         len_m1, n;
   logic signed [16:0]                diff_t, d1, d2;
   logic signed [33:0]                sq;
   logic [psvu_pkg::ScoreW-1:0]       acc_in, pold;
   logic                              pupd, gupd;
   logic signed [psvu_pkg::SumW-1:0]  adj;
   logic signed [24:0]                q, lim, q_clamp;

   always_comb begin
      if (vlen_ff == 4'd0) begin
         len_m1 = '0;
      end else if (vlen_ff > 4'(psvu_pkg::MaxDim)) begin
         len_m1 = psvu_pkg::DimW'(psvu_pkg::MaxDim - 1);
      end else begin
         len_m1 = psvu_pkg::DimW'(vlen_ff - 4'd1);
      end
      n = (cnt_ff > len_m1) ? len_m1 : cnt_ff;
   end

   assign diff_t = {target[15], target} - {position[15], position};
   assign sq     = diff_t * diff_t;
   assign acc_in = acc_ff + psvu_pkg::ScoreW'(sq[32:0]);

   assign pold = scv_rd_ff ? sc_rd_ff : psvu_pkg::SCORE_MAX;
   assign pupd = first_ff || (score_ff < pold);
   assign gupd = score_ff < gscore_ff;

   assign sts.in_last = (n == len_m1);
   assign sts.opt     = opt_ff;
   assign sts.pupd    = pupd;
   assign sts.len_m1  = len_m1;

   assign d1 = {pb_rd_ff[15], pb_rd_ff} - {p_rd_ff[15], p_rd_ff};
   assign d2 = {gb_rd_ff[15], gb_rd_ff} - {p_rd_ff[15], p_rd_ff};

   // truncate toward zero, then clamp
   always_comb begin
      adj = s_ff + (s_ff[psvu_pkg::SumW-1] ?
            psvu_pkg::SumW'((64'd1 << psvu_pkg::ScaleShift) - 64'd1) : '0);
      q   = 25'(adj >>> psvu_pkg::ScaleShift);
      lim = {10'd0, vlim_ff};
      if (q > lim) begin
         q_clamp = lim;
      end else if (q < -lim) begin
         q_clamp = -lim;
      end else begin
         q_clamp = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff      <= 16'sd4096;
         c1_ff     <= 16'sd4096;
         c2_ff     <= 16'sd4096;
         vlim_ff   <= 15'd32767;
         vlen_ff   <= 4'd2;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         scv_ff    <= '0;
         gscore_ff <= psvu_pkg::SCORE_MAX;
      end else begin
         if (csr_we) begin
            case (csr_index)
               psvu_pkg::CSR_INERTIA: w_ff    <= csr_data;
               psvu_pkg::CSR_PGAIN:   c1_ff   <= csr_data;
               psvu_pkg::CSR_GGAIN:   c2_ff   <= csr_data;
               psvu_pkg::CSR_VLIMIT:  vlim_ff <= csr_data[14:0];
               psvu_pkg::CSR_VLENGTH: vlen_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            acc_ff    <= '0;
            cnt_ff    <= '0;
            scv_ff    <= '0;
            gscore_ff <= psvu_pkg::SCORE_MAX;
         end else if (cmd.load) begin
            if (sts.in_last) begin
               acc_ff <= '0;
               cnt_ff <= '0;
            end else begin
               acc_ff <= acc_in;
               cnt_ff <= n + 1'b1;
            end
         end
         if (cmd.cmp) begin
            if (pupd) begin
               scv_ff[p_ff] <= 1'b1;
            end
            if (gupd) begin
               gscore_ff <= score_ff;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pbuf_ff[n] <= position;
         vbuf_ff[n] <= velocity;
         sc_rd_ff   <= sc_mem[particle_index];
         scv_rd_ff  <= scv_ff[particle_index];
         if (sts.in_last) begin
            score_ff <= acc_in;
            p_ff     <= particle_index;
            opt_ff   <= set_opt;
            first_ff <= set_first;
            r1_ff    <= rand_one;
            r2_ff    <= rand_two;
         end
      end
      if (cmd.cmp) begin
         if (pupd) begin
            sc_mem[p_ff] <= score_ff;
         end
         for (int i = 0; i < psvu_pkg::MaxDim; i++) begin
            if (gupd && (psvu_pkg::DimW'(i) <= len_m1)) begin
               gpos_ff[i] <= pbuf_ff[i];
            end
         end
         k1_ff <= c1_ff * $signed({1'b0, r1_ff});
         k2_ff <= c2_ff * $signed({1'b0, r2_ff});
      end
      if (cmd.copy) begin
         pb_mem[{p_ff, cmd.idx}] <= pbuf_ff[cmd.idx];
      end
      if (cmd.rd) begin
         pb_rd_ff <= pb_mem[{p_ff, cmd.idx}];
         gb_rd_ff <= gpos_ff[cmd.idx];
         p_rd_ff  <= pbuf_ff[cmd.idx];
         v_rd_ff  <= vbuf_ff[cmd.idx];
         idx_ff   <= cmd.idx;
      end
      if (cmd.mul) begin
         pv_ff <= w_ff * v_rd_ff;
         m1_ff <= k1_ff * d1;
         m2_ff <= k2_ff * d2;
      end
      if (cmd.sum) begin
         s_ff <= (psvu_pkg::SumW'(pv_ff) <<< 16) + psvu_pkg::SumW'(m1_ff)
               + psvu_pkg::SumW'(m2_ff);
      end
      if (cmd.rnd) begin
         nv_ff   <= q_clamp[15:0];
         eidx_ff <= idx_ff;
         last_ff <= (idx_ff == len_m1);
      end
   end

   assign new_velocity  = nv_ff;
   assign element_index = eidx_ff;
   assign last          = last_ff;

endmodule

/* rtl/core/psvu_ctrl.sv */
module psvu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [1:0]        op,
   input  logic              rsp_tready,
   input  psvu_pkg::sts_type sts,
   output logic              req_tready,
   output logic              rsp_tvalid,
   output logic              set_opt,
   output logic              set_first,
   output psvu_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_COPY = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_SUM  = 3'd5;
   localparam logic [2:0] S_RND  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [psvu_pkg::DimW-1:0] idx_ff, idx_in;
   logic                      acc, is_load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign acc        = req_tvalid && req_tready;
   assign is_load    = acc && ((op == psvu_pkg::OP_FIRST) || (op == psvu_pkg::OP_OPT));
   assign set_opt    = is_load && sts.in_last && (op == psvu_pkg::OP_OPT);
   assign set_first  = is_load && sts.in_last && (op == psvu_pkg::OP_FIRST);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.idx   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.clear = acc && (op == psvu_pkg::OP_CLEAR);
            cmd.load  = is_load;
            if (is_load && sts.in_last) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            idx_in  = '0;
            if (sts.pupd) begin
               state_in = S_COPY;
            end else if (sts.opt) begin
               state_in = S_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (idx_ff == sts.len_m1) begin
               idx_in   = '0;
               state_in = sts.opt ? S_RD : S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (idx_ff == sts.len_m1) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

/* rtl/core/particle_swarm_velocity_update.sv */
// Sequence: each accepted item loads one element; on the last element a compare step, then
//   a copy of the effective vector length when the personal best changes, then, for optimize,
//   read, multiply, sum and round steps for each element before its result is shown.
//   The controller works one item at a time and takes no new item until it is back in idle.
// Reset (synchronous, active high): registers to reset values, all best scores maximum,
//   element counter and distance sum zero; best positions stay undefined until written.
module particle_swarm_velocity_update (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // particle_index[5:0], position[21:6], velocity[37:22], target[53:38],
   // rand_one[69:54], rand_two[85:70], zero pad[87:86]
   input  logic [87:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_velocity[15:0], element_index[18:16], zero pad[23:19]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   psvu_pkg::cmd_type         cmd;
   psvu_pkg::sts_type         sts;
   logic [15:0]               new_velocity;
   logic [psvu_pkg::DimW-1:0] element_index;
   logic                      last, set_opt, set_first;

   // register writes are taken only while the controller is idle
   assign csr_ready = req_tready;

   psvu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .op         (req_tuser),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .set_opt    (set_opt),
      .set_first  (set_first),
      .cmd        (cmd)
   );

   psvu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .particle_index (req_tdata[5:0]),
      .position       (req_tdata[21:6]),
      .velocity       (req_tdata[37:22]),
      .target         (req_tdata[53:38]),
      .rand_one       (req_tdata[69:54]),
      .rand_two       (req_tdata[85:70]),
      .set_opt        (set_opt),
      .set_first      (set_first),
      .cmd            (cmd),
      .sts            (sts),
      .new_velocity   (new_velocity),
      .element_index  (element_index),
      .last           (last)
   );

   assign rsp_tdata = {5'd0, element_index, new_velocity};
   assign rsp_tlast = last;

endmodule

/* rtl/core/psvu_checker.sv */
`include "particle_swarm_velocity_update_defines.svh"

module psvu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a waiting result holds until taken
   `PSVU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // no input is taken while a result is shown
   `PSVU_ASSERT_NOW(a_no_overlap, rsp_tvalid, !req_tready)
   // each result is followed by a gap while the next one is computed
   `PSVU_ASSERT_NEXT(a_rsp_gap, rsp_tvalid && rsp_tready, !rsp_tvalid)
   // clamp is symmetric, so the most negative code never appears
   `PSVU_ASSERT_NOW(a_clamp, rsp_tvalid, rsp_tdata[15:0] != 16'h8000)
   // register writes land only while idle
   `PSVU_ASSERT_NOW(a_csr_idle, csr_valid && csr_ready, req_tready)

endmodule

bind particle_swarm_velocity_update psvu_checker u_psvu_checker (.*);

/* verif/tb_particle_swarm_velocity_update.sv */
`timescale 1ns / 1ps

module tb_particle_swarm_velocity_update;

   // operation code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all
   localparam int SETTLE = 60;          // compare + copy + pipeline slack

   // Mirror of the swarm state; predicts the new velocity items.
   class velocity_predictor;
      typedef struct {
         logic [15:0] vel;
         logic [2:0]  idx;
         logic        last;
      } velocity_item_type;

      velocity_item_type expected_velocities[$];
      int           errors;
      shortint      w, c1, c2;
      int           lim;
      int           vlen;
      shortint      pb_pos[64][8];
      bit           pb_ok[64][8];
      logic [40:0]  pb_score[64];
      shortint      gb_pos[8];
      bit           gb_ok[8];
      logic [40:0]  gb_score;
      shortint      pos_buf[8];
      shortint      vel_buf[8];
      logic [40:0]  dist_sum;
      int           cnt;

      function new();
         w = 4096; c1 = 4096; c2 = 4096; lim = 32767; vlen = 2;
         errors = 0; dist_sum = '0; cnt = 0;
         foreach (pb_score[i]) pb_score[i] = '1;
         gb_score = '1;
      endfunction

      function int eff_len();
         if (vlen == 0) return 1;
         if (vlen > psvu_pkg::MaxDim) return psvu_pkg::MaxDim;
         return vlen;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            psvu_pkg::CSR_INERTIA: w = data;
            psvu_pkg::CSR_PGAIN:   c1 = data;
            psvu_pkg::CSR_GGAIN:   c2 = data;
            psvu_pkg::CSR_VLIMIT:  lim = data[14:0];
            psvu_pkg::CSR_VLENGTH: vlen = data[3:0];
            default: ;
         endcase
      endfunction

      // next op 1/2 item closes the vector
      function bit ends_vector();
         return cnt >= eff_len() - 1;
      endfunction

      function bit gb_covers();
         for (int i = 0; i < eff_len(); i++)
            if (!gb_ok[i]) return 0;
         return 1;
      endfunction

      // optimize only reads best entries that were already written
      function bit opt_safe(int p);
         for (int i = 0; i < eff_len(); i++)
            if (!pb_ok[p][i] || !gb_ok[i]) return 0;
         return 1;
      endfunction

      function void note_item(logic [1:0] op, logic [5:0] pidx, shortint pos,
                              shortint vel, shortint tgt, bit [15:0] r1, bit [15:0] r2);
         int           len, n, p;
         longint       d, s, q, k1, k2, pi;
         logic [40:0]  score;
         velocity_item_type e;
         if (op == OP_UNUSED) return;
         if (op == psvu_pkg::OP_CLEAR) begin
            foreach (pb_score[i]) pb_score[i] = '1;
            gb_score = '1;
            dist_sum = '0;
            cnt = 0;
            return;
         end
         len = eff_len();
         n = (cnt >= len) ? len - 1 : cnt;
         pos_buf[n] = pos;
         vel_buf[n] = vel;
         d = longint'(tgt) - longint'(pos);
         dist_sum = dist_sum + 41'(d * d);
         if (n + 1 < len) begin
            cnt = n + 1;
            return;
         end
         score = dist_sum;
         dist_sum = '0;
         cnt = 0;
         p = pidx;
         if (op == psvu_pkg::OP_FIRST || score < pb_score[p]) begin
            pb_score[p] = score;
            for (int i = 0; i < len; i++) begin
               pb_pos[p][i] = pos_buf[i];
               pb_ok[p][i] = 1;
            end
         end
         if (score < gb_score) begin
            gb_score = score;
            for (int i = 0; i < len; i++) begin
               gb_pos[i] = pos_buf[i];
               gb_ok[i] = 1;
            end
         end
         if (op == psvu_pkg::OP_FIRST) return;
         k1 = longint'(c1) * longint'(r1);
         k2 = longint'(c2) * longint'(r2);
         for (int i = 0; i < len; i++) begin
            pi = pos_buf[i];
            // Q.28 sum, truncated toward zero
            s = longint'(w) * longint'(vel_buf[i]) * 65536
              + k1 * (longint'(pb_pos[p][i]) - pi)
              + k2 * (longint'(gb_pos[i]) - pi);
            q = (s < 0) ? -((-s) >>> psvu_pkg::ScaleShift) : (s >>> psvu_pkg::ScaleShift);
            if (q > lim) q = lim;
            if (q < -lim) q = -lim;
            e.vel = q[15:0];
            e.idx = i[2:0];
            e.last = (i + 1 == len);
            expected_velocities.push_back(e);
         end
      endfunction

      function void check_velocity(logic [15:0] vel, logic [2:0] idx, logic last);
         velocity_item_type e;
         if (expected_velocities.size() == 0) begin
            $display("%0t: unexpected velocity item vel %0d idx %0d last %0b",
                     $time, $signed(vel), idx, last);
            errors++;
            return;
         end
         e = expected_velocities.pop_front();
         if (vel !== e.vel) begin
            $display("%0t: new_velocity exp %0d got %0d", $time, $signed(e.vel), $signed(vel));
            errors++;
         end
         if (idx !== e.idx) begin
            $display("%0t: element_index exp %0d got %0d", $time, e.idx, idx);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last exp %0b got %0b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   velocity_predictor sb = new();

   int send_idle = 25;    // percent of cycles the sender sits out
   int recv_idle = 45;    // percent of cycles the receiver stalls
   logic hold_go = 1'b0;  // request one long receiver hold-off
   bit   hold_done = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   particle_swarm_velocity_update u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up
   // into its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Result checker; samples the pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_velocity(rsp_tdata[15:0], rsp_tdata[18:16], rsp_tlast);
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Extremes show up often; otherwise any 16-bit value.
   function automatic logic [15:0] pick16();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // Wait for every expected velocity, then let trailing no-result work settle.
   task automatic drain();
      while (sb.expected_velocities.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_item(logic [1:0] op, logic [5:0] p, logic [15:0] pos,
                            logic [15:0] vel, logic [15:0] tgt,
                            logic [15:0] r1, logic [15:0] r2);
      logic [1:0] o;
      o = op;
      // never let an optimize pass read a best entry nobody wrote
      if (o == psvu_pkg::OP_OPT && sb.ends_vector() && !sb.opt_safe(p)) o = psvu_pkg::OP_FIRST;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= o;
      req_tdata <= {2'b00, r2, r1, tgt, vel, pos, p};
      do @(posedge clock); while (!req_tready);
      sb.note_item(o, p, pos, vel, tgt, r1, r2);
   endtask

   task automatic send_vector(ref int sent);
      logic [5:0] p;
      logic [5:0] pe;
      logic [1:0] op;
      bit         done;
      p = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(7));
      do begin
         done = sb.ends_vector();
         if (done) op = ($urandom_range(3) == 0) ? psvu_pkg::OP_FIRST : psvu_pkg::OP_OPT;
         else op = $urandom_range(1) ? psvu_pkg::OP_OPT : psvu_pkg::OP_FIRST;
         // earlier elements may carry stray particle numbers
         pe = (!done && $urandom_range(4) == 0) ? 6'($urandom()) : p;
         push_item(op, pe, pick16(), pick16(), pick16(), pick16(), pick16());
         sent++;
      end while (!done);
   endtask

   task automatic run_random(int n);
      int sent;
      sent = 0;
      // a clear first so the global best covers the whole vector length
      if (!sb.gb_covers())
         push_item(psvu_pkg::OP_CLEAR, 6'($urandom()), pick16(), pick16(), pick16(),
                   pick16(), pick16());
      while (sent < n) begin
         if ($urandom_range(99) < 85) begin
            send_vector(sent);
         end else begin
            // noise: mostly lone elements, sometimes ignored or clear items
            case ($urandom_range(9))
               0: push_item(psvu_pkg::OP_CLEAR, 6'($urandom()), pick16(), pick16(), pick16(),
                            pick16(), pick16());
               1, 2: push_item(OP_UNUSED, 6'($urandom()), pick16(), pick16(), pick16(),
                               pick16(), pick16());
               default: push_item(2'($urandom_range(1, 2)), 6'($urandom()), pick16(),
                                  pick16(), pick16(), pick16(), pick16());
            endcase
            sent++;
         end
      end
      // leave a partial vector behind to cross the next register change
      push_item(psvu_pkg::OP_FIRST, 6'($urandom()), pick16(), pick16(), pick16(), pick16(),
                pick16());
      req_tvalid <= 1'b0;
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings (vector length 2).
      push_item(OP_UNUSED, 6'd5, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
      // largest distance, first pass for particle 0
      push_item(psvu_pkg::OP_FIRST, 6'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
      push_item(psvu_pkg::OP_FIRST, 6'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
      // optimize, full randoms and zero randoms
      push_item(psvu_pkg::OP_OPT, 6'd0, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
      push_item(psvu_pkg::OP_OPT, 6'd0, 16'h0000, 16'h7fff, 16'h0010, 16'hffff, 16'hffff);
      // same vector again: tie, bests kept
      push_item(psvu_pkg::OP_OPT, 6'd0, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
      push_item(psvu_pkg::OP_OPT, 6'd0, 16'h0000, 16'h7fff, 16'h0010, 16'h0000, 16'hffff);
      // mixed items: first element says particle 9 and optimize, last decides
      push_item(psvu_pkg::OP_OPT, 6'd9, 16'h0001, 16'h0002, 16'h0001, 16'h1234, 16'h4321);
      push_item(psvu_pkg::OP_FIRST, 6'd63, 16'hffff, 16'h0100, 16'hfffe, 16'h8000, 16'h8000);
      push_item(psvu_pkg::OP_FIRST, 6'd63, 16'h0004, 16'hff00, 16'h0004, 16'h8000, 16'h8000);
      push_item(psvu_pkg::OP_OPT, 6'd63, 16'h0003, 16'h7fff, 16'h0004, 16'hffff, 16'hffff);
      // clear abandons this half vector
      push_item(psvu_pkg::OP_OPT, 6'd63, 16'h1111, 16'h2222, 16'h3333, 16'h0000, 16'h0000);
      push_item(psvu_pkg::OP_CLEAR, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_item(psvu_pkg::OP_OPT, 6'd63, 16'h0100, 16'h0200, 16'h0300, 16'h7fff, 16'h7fff);
      push_item(psvu_pkg::OP_OPT, 6'd63, 16'hff00, 16'hfe00, 16'hfd00, 16'h7fff, 16'h7fff);
      // half a vector left open; length lowered under it below
      push_item(psvu_pkg::OP_FIRST, 6'd3, 16'h0040, 16'h0040, 16'h0000, 16'h0000, 16'h0000);
      req_tvalid <= 1'b0;
      drain();
      write_csr(psvu_pkg::CSR_VLENGTH, 16'd1);
      push_item(psvu_pkg::OP_OPT, 6'd63, 16'h0050, 16'h0060, 16'h0070, 16'hffff, 16'hffff);
      req_tvalid <= 1'b0;
      drain();

      // Phase: longest vectors, extreme gains, with the long receiver hold-off.
      write_csr(psvu_pkg::CSR_VLENGTH, 16'd8);
      write_csr(psvu_pkg::CSR_INERTIA, 16'h8000);
      write_csr(psvu_pkg::CSR_PGAIN, 16'h7fff);
      write_csr(psvu_pkg::CSR_GGAIN, 16'h8000);
      write_csr(psvu_pkg::CSR_VLIMIT, 16'h7fff);
      hold_go <= 1'b1;
      run_random(60);

      // Phase: single dimension, zero limit.
      send_idle = 45;
      recv_idle = 25;
      write_csr(psvu_pkg::CSR_VLENGTH, 16'd1);
      write_csr(psvu_pkg::CSR_VLIMIT, 16'h0000);
      write_csr(psvu_pkg::CSR_INERTIA, 16'h7fff);
      write_csr(psvu_pkg::CSR_PGAIN, 16'h8000);
      write_csr(psvu_pkg::CSR_GGAIN, 16'h7fff);
      run_random(40);

      // Phase: length zero acts as one, small limit.
      write_csr(psvu_pkg::CSR_VLENGTH, 16'd0);
      write_csr(psvu_pkg::CSR_VLIMIT, 16'd1000);
      write_csr(psvu_pkg::CSR_INERTIA, 16'($urandom()));
      run_random(40);

      // Phase: length above the maximum, random gains.
      send_idle = 0;
      recv_idle = 0;
      write_csr(psvu_pkg::CSR_VLENGTH, 16'd15);
      write_csr(psvu_pkg::CSR_INERTIA, 16'($urandom()));
      write_csr(psvu_pkg::CSR_PGAIN, 16'($urandom()));
      write_csr(psvu_pkg::CSR_GGAIN, 16'($urandom()));
      write_csr(psvu_pkg::CSR_VLIMIT, 16'($urandom_range(1, 32767)));
      run_random(60);

      // Phase: medium length, unit gains.
      write_csr(psvu_pkg::CSR_VLENGTH, 16'd3);
      write_csr(psvu_pkg::CSR_INERTIA, 16'd4096);
      write_csr(psvu_pkg::CSR_PGAIN, 16'd4096);
      write_csr(psvu_pkg::CSR_GGAIN, 16'd4096);
      write_csr(psvu_pkg::CSR_VLIMIT, 16'h7fff);
      run_random(60);

      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/psvu_pkg.sv
rtl/core/psvu_dp.sv
rtl/core/psvu_ctrl.sv
rtl/core/particle_swarm_velocity_update.sv
rtl/core/psvu_checker.sv
verif/tb_particle_swarm_velocity_update.sv
